### rtl/core/m4vt_pkg.sv
// m4vt_pkg: shared types and constants for the 4x4 matrix-vector transform
// no dependencies; imported by the interfaces and all rtl/core modules
`default_nettype none

package m4vt_pkg;

	localparam int unsigned LANES = 4;

	typedef logic signed [31:0] q16_t;
	typedef q16_t [LANES-1:0] quad_t;
	typedef logic signed [65:0] acc_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_XFORM = 1'b1
	} op_t;

	localparam q16_t Q_MAX = 32'sh7fff_ffff;
	localparam q16_t Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		op_t        op;
		logic [1:0] entry_row;
		logic [1:0] entry_col;
		q16_t       entry_value;
		q16_t       vec_x;
		q16_t       vec_y;
		q16_t       vec_z;
		q16_t       vec_w;
	} in_word_t;

	typedef struct packed {
		q16_t out_x;
		q16_t out_y;
		q16_t out_z;
		q16_t out_w;
	} out_word_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} lane_ctl_t;

endpackage

`default_nettype wire

### rtl/core/m4vt_if.sv
// m4vt_in_if / m4vt_out_if: valid-ready channels for command and result words
// depends on m4vt_pkg
`default_nettype none

interface m4vt_in_if;
	import m4vt_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface m4vt_out_if;
	import m4vt_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/matrix4_vector_transform.sv
// matrix4_vector_transform: top level, matrix store, lane array, stage control
// depends on m4vt_pkg, m4vt_if, m4vt_lane, m4vt_merge
//
// A load word writes one Q16.16 matrix entry in the cycle it is accepted and
// gives no result; the next word already sees the new entry. A transform word
// runs through four parallel row lanes (32x32 multiplies, then a 65-bit and a
// 66-bit add stage) and a saturating output register, so its result is held in
// the product, pair-sum, lane-sum and output registers in turn. One word is
// accepted per clock; each stage holds when the stage after it is full and
// stalled, so bubbles close up and new words are taken while a finished
// result waits at the output. The matrix is all zero after reset.
`default_nettype none

module matrix4_vector_transform (
	input  logic        clk,
	input  logic        arst_n,
	m4vt_in_if.sink     cmd,
	m4vt_out_if.source  result
);
	import m4vt_pkg::*;

	q16_t      mat_q [16];
	logic      xf_s1, xf_s2, xf_s3;
	logic      en_out;
	lane_ctl_t ctl;
	quad_t     vec;
	acc_t      acc [LANES];
	logic      accept;

	assign ctl.en_s3 = !xf_s3 || en_out;
	assign ctl.en_s2 = !xf_s2 || ctl.en_s3;
	assign ctl.en_s1 = !xf_s1 || ctl.en_s2;

	assign cmd.ready = ctl.en_s1;
	assign accept    = cmd.valid && ctl.en_s1;

	assign vec[0] = cmd.data.vec_x;
	assign vec[1] = cmd.data.vec_y;
	assign vec[2] = cmd.data.vec_z;
	assign vec[3] = cmd.data.vec_w;

	// matrix store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= '0;
			end
		end else if (accept && cmd.data.op == OP_LOAD) begin
			mat_q[{cmd.data.entry_row, cmd.data.entry_col}] <= cmd.data.entry_value;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xf_s1 <= 1'b0;
			xf_s2 <= 1'b0;
			xf_s3 <= 1'b0;
		end else begin
			if (ctl.en_s1) begin
				xf_s1 <= accept && cmd.data.op == OP_XFORM;
			end
			if (ctl.en_s2) begin
				xf_s2 <= xf_s1;
			end
			if (ctl.en_s3) begin
				xf_s3 <= xf_s2;
			end
		end
	end

	for (genvar r = 0; r < LANES; r++) begin : g_lane
		quad_t row;
		for (genvar c = 0; c < LANES; c++) begin : g_col
			assign row[c] = mat_q[r*LANES + c];
		end
		m4vt_lane u_lane (
			.clk (clk),
			.ctl (ctl),
			.row (row),
			.vec (vec),
			.acc (acc[r])
		);
	end

	m4vt_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.valid_s3 (xf_s3),
		.en_out   (en_out),
		.result   (result)
	);

endmodule

`default_nettype wire

### rtl/core/m4vt_lane.sv
// m4vt_lane: one matrix row dotted with the vector, multiply then two add stages
// depends on m4vt_pkg
`default_nettype none

module m4vt_lane (
	input  logic                  clk,
	input  m4vt_pkg::lane_ctl_t   ctl,
	input  m4vt_pkg::quad_t       row,
	input  m4vt_pkg::quad_t       vec,
	output m4vt_pkg::acc_t        acc
);
	import m4vt_pkg::*;

	logic signed [63:0] prod_s1 [LANES];
	logic signed [64:0] pair_s2 [2];
	acc_t               acc_s3;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int c = 0; c < LANES; c++) begin
				prod_s1[c] <= 64'($signed(row[c])) * 64'($signed(vec[c]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			pair_s2[0] <= 65'(prod_s1[0]) + 65'(prod_s1[1]);
			pair_s2[1] <= 65'(prod_s1[2]) + 65'(prod_s1[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			acc_s3 <= 66'(pair_s2[0]) + 66'(pair_s2[1]);
		end
	end

	assign acc = acc_s3;

endmodule

`default_nettype wire

### rtl/core/m4vt_merge.sv
// m4vt_merge: shifts and saturates the four lane sums into one result word register
// depends on m4vt_pkg and m4vt_out_if
`default_nettype none

module m4vt_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  m4vt_pkg::acc_t    acc [4],
	input  logic              valid_s3,
	output logic              en_out,
	m4vt_out_if.source        result
);
	import m4vt_pkg::*;

	logic      out_valid_q;
	out_word_t word_q;

	function automatic q16_t sat16(acc_t a);
		logic fits;
		fits = (a[65:47] == '0) || (a[65:47] == '1);
		if (fits) begin
			return a[47:16];
		end else if (a[65]) begin
			return Q_MIN;
		end
		return Q_MAX;
	endfunction

	assign en_out = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s3) begin
			word_q.out_x <= sat16(acc[0]);
			word_q.out_y <= sat16(acc[1]);
			word_q.out_z <= sat16(acc[2]);
			word_q.out_w <= sat16(acc[3]);
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = word_q;

endmodule

`default_nettype wire
